// ===== rtl/core/bpegp_pkg.sv =====
// Shared types, constants and codes for the breakpoint envelope gain/pan block.
// No dependencies; every other file in rtl/core imports this package.
package bpegp_pkg;

  localparam int DEFAULT_MAX_POINTS     = 256;
  localparam int DEFAULT_SAMPLE_BITS    = 24;
  localparam int DEFAULT_PAN_TABLE_SIZE = 1024;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 20;
  localparam int INT_W   = 16;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_W   = 53;
  localparam int QUOT_W  = 22;
  localparam int GAIN_W  = 17;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [INT_W-1:0] INTENSITY_RESET = 16'd16384;
  localparam longint ONE_Q16     = 65536;
  localparam longint HALF_PI_Q30 = 1686629713;

  // Register index, taken from paddr[2].
  localparam logic REG_INTENSITY = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_PROCESS = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN0, S_SCAN, S_INTERP_MUL, S_DIV_GO, S_DIV_WAIT,
    S_GAIN_MUL, S_GAIN_FIX, S_PAN_CLAMP, S_PAN_IDX, S_ROM_R, S_ROM_L,
    S_MUL_L, S_MUL_R, S_OUT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  ptime;
    logic [VALUE_W-1:0] pval;
  } point_t;

  typedef struct packed {
    logic               mul_go;
    logic               div_go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [TIME_W-1:0]  divisor;
  } arith_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
  } arith_stat_t;

endpackage

// ===== rtl/core/bpegp_point_mem.sv =====
// Breakpoint table: one write port, one registered read port.
// Depends on bpegp_pkg for point_t.
module bpegp_point_mem #(
  parameter int MaxPoints = bpegp_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MaxPoints)-1:0] waddr_i,
  input  bpegp_pkg::point_t            wdata_i,
  input  logic [$clog2(MaxPoints)-1:0] raddr_i,
  output bpegp_pkg::point_t            rdata_o
);
  import bpegp_pkg::*;

  point_t mem_q [MaxPoints];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bpegp_sine_rom.sv =====
// Quarter-wave sine ROM in Q16, built at elaboration by a seven-term series.
// Registered read. Depends on bpegp_pkg.
module bpegp_sine_rom #(
  parameter int PanTableSize = bpegp_pkg::DEFAULT_PAN_TABLE_SIZE
) (
  input  logic                              clk_i,
  input  logic [$clog2(PanTableSize+1)-1:0] addr_i,
  output logic [bpegp_pkg::GAIN_W-1:0]      data_o
);
  import bpegp_pkg::*;

  localparam longint Q30 = 64'sd1 <<< 30;

  logic [GAIN_W-1:0] rom_w [PanTableSize+1];
  logic [GAIN_W-1:0] data_q;

  for (genvar k = 0; k <= PanTableSize; k++) begin : g_entry
    // angle k * (pi/2) / N in Q30, then the odd terms of the series
    localparam longint X  = longint'(k) * HALF_PI_Q30 / longint'(PanTableSize);
    localparam longint A1 = X * X / Q30;
    localparam longint B1 = A1 * X / Q30;
    localparam longint T1 = -B1 / 64'sd6;
    localparam longint A2 = T1 * X / Q30;
    localparam longint B2 = A2 * X / Q30;
    localparam longint T2 = -B2 / 64'sd20;
    localparam longint A3 = T2 * X / Q30;
    localparam longint B3 = A3 * X / Q30;
    localparam longint T3 = -B3 / 64'sd42;
    localparam longint A4 = T3 * X / Q30;
    localparam longint B4 = A4 * X / Q30;
    localparam longint T4 = -B4 / 64'sd72;
    localparam longint A5 = T4 * X / Q30;
    localparam longint B5 = A5 * X / Q30;
    localparam longint T5 = -B5 / 64'sd110;
    localparam longint A6 = T5 * X / Q30;
    localparam longint B6 = A6 * X / Q30;
    localparam longint T6 = -B6 / 64'sd156;
    localparam longint S  = X + T1 + T2 + T3 + T4 + T5 + T6;
    // round to Q16 and clamp to 0..1.0
    localparam longint QR = (S + 64'sd8192) >>> 14;
    localparam longint QC = (QR < 64'sd0) ? 64'sd0 : ((QR > ONE_Q16) ? ONE_Q16 : QR);
    assign rom_w[k] = GAIN_W'(QC);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/bpegp_arith.sv =====
// Shared arithmetic unit: registered signed multiplier and a radix-2
// restoring divider that divides the magnitude of the last product.
// Depends on bpegp_pkg.
module bpegp_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpegp_pkg::arith_ctrl_t ctrl_i,
  output bpegp_pkg::arith_stat_t stat_o
);
  import bpegp_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0]        prod_abs;
  logic [DIV_W-1:0]         dvd_q, dvd_d;
  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [TIME_W-1:0]        dsr_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     neg_q;
  logic [TIME_W:0]          rem_sh;
  logic                     fits;
  logic [QUOT_W-1:0]        quot_mag;

  assign prod_d   = $signed(ctrl_i.a) * $signed(ctrl_i.b);
  assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign rem_sh   = {rem_q, dvd_q[DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.div_go) begin
      dvd_d  = prod_abs[DIV_W-1:0];
      rem_d  = '0;
      cnt_d  = CntW'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? TIME_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[TIME_W-1:0];
      dvd_d  = {dvd_q[DIV_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_go) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.div_go) begin
      dsr_q <= ctrl_i.divisor;
      neg_q <= prod_q[PROD_W-1];
    end
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quot_mag    = dvd_q[QUOT_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.prod = prod_q;
  assign stat_o.quot = neg_q ? QUOT_W'(-quot_mag) : quot_mag;

endmodule

// ===== rtl/core/bpegp_ctrl.sv =====
// Sequencer and datapath registers: table loads, segment scan, interpolation,
// gain or pan lookup, sample scaling and the output register.
// Depends on bpegp_pkg; drives bpegp_point_mem, bpegp_sine_rom, bpegp_arith.
module bpegp_ctrl #(
  parameter int MaxPoints    = bpegp_pkg::DEFAULT_MAX_POINTS,
  parameter int SampleBits   = bpegp_pkg::DEFAULT_SAMPLE_BITS,
  parameter int PanTableSize = bpegp_pkg::DEFAULT_PAN_TABLE_SIZE
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [bpegp_pkg::TIME_W-1:0]          point_time_i,
  input  logic signed [bpegp_pkg::VALUE_W-1:0]  point_value_i,
  input  logic signed [SampleBits-1:0]          left_in_i,
  input  logic signed [SampleBits-1:0]          right_in_i,
  input  logic [bpegp_pkg::INT_W-1:0]           intensity_i,
  input  logic                                  mode_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SampleBits-1:0]          left_out_o,
  output logic signed [SampleBits-1:0]          right_out_o,
  output logic signed [bpegp_pkg::VALUE_W-1:0]  envelope_level_o,
  output logic                                  mem_we_o,
  output logic [$clog2(MaxPoints)-1:0]          mem_waddr_o,
  output bpegp_pkg::point_t                     mem_wdata_o,
  output logic [$clog2(MaxPoints)-1:0]          mem_raddr_o,
  input  bpegp_pkg::point_t                     mem_rdata_i,
  output logic [$clog2(PanTableSize+1)-1:0]     rom_addr_o,
  input  logic [bpegp_pkg::GAIN_W-1:0]          rom_data_i,
  output bpegp_pkg::arith_ctrl_t                arith_ctrl_o,
  input  bpegp_pkg::arith_stat_t                arith_stat_i
);
  import bpegp_pkg::*;

  localparam int AddrW  = $clog2(MaxPoints);
  localparam int CntW   = $clog2(MaxPoints + 1);
  localparam int RomAW  = $clog2(PanTableSize + 1);
  localparam int KW     = PROD_W - 31;
  localparam logic signed [PROD_W-1:0] PanLim  = 57'sd1 <<< 30;
  localparam logic signed [PROD_W-1:0] SampHi  = (57'sd1 <<< (SampleBits - 1)) - 57'sd1;
  localparam logic signed [PROD_W-1:0] SampLo  = -SampHi - 57'sd1;

  function automatic logic [SampleBits-1:0] round_sat(input logic [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    y = ($signed(x) + 57'sd32768) >>> 16;
    if (y > SampHi) y = SampHi;
    if (y < SampLo) y = SampLo;
    return y[SampleBits-1:0];
  endfunction

  state_e                     state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [TIME_W-1:0]          pos_q, pos_d;
  logic [AddrW-1:0]           idx_q, idx_d;
  logic [TIME_W-1:0]          t1_q, t1_d, t2_q, t2_d;
  logic signed [VALUE_W-1:0]  v1_q, v1_d, last_q, last_d, env_q, env_d;
  logic [VALUE_W:0]           diff_q, diff_d;
  logic signed [SampleBits-1:0] left_q, left_d, right_q, right_d;
  logic signed [MUL_B_W-1:0]  gl_q, gl_d, gr_q, gr_d;
  logic [RomAW-1:0]           k_q, k_d;
  logic [SampleBits-1:0]      lo_q, lo_d;
  logic                       out_valid_q, out_valid_d;
  logic [SampleBits-1:0]      lout_q, lout_d, rout_q, rout_d;
  logic [VALUE_W-1:0]         eout_q, eout_d;

  logic signed [PROD_W-1:0]   prod_s;
  logic signed [PROD_W-1:0]   p_clamp;
  logic [PROD_W-1:0]          k_sum;
  logic [KW-1:0]              k_sh;
  logic signed [PROD_W-1:0]   g_full;
  logic [VALUE_W:0]           env_m1;
  logic [VALUE_W:0]           interp;
  logic                       accept;
  logic                       scan_hit;

  assign prod_s   = $signed(arith_stat_i.prod);
  assign p_clamp  = (prod_s > PanLim) ? PanLim : ((prod_s < -PanLim) ? -PanLim : prod_s);
  assign k_sum    = PROD_W'(prod_s + PanLim);
  assign k_sh     = k_sum[PROD_W-1:31];
  assign g_full   = 57'sd65536 + ((prod_s + 57'sd8192) >>> 14);
  assign env_m1   = {env_q[VALUE_W-1], env_q} - 21'd65536;
  assign interp   = {v1_q[VALUE_W-1], v1_q} + arith_stat_i.quot[VALUE_W:0];
  assign accept   = in_valid_i && in_ready_o;
  assign scan_hit = (pos_q >= t1_q) && (pos_q <= mem_rdata_i.ptime);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    v1_d        = v1_q;
    last_d      = last_q;
    env_d       = env_q;
    diff_d      = diff_q;
    left_d      = left_q;
    right_d     = right_q;
    gl_d        = gl_q;
    gr_d        = gr_q;
    k_d         = k_q;
    lo_d        = lo_q;
    lout_d      = lout_q;
    rout_d      = rout_q;
    eout_d      = eout_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AddrW-1:0];
    mem_wdata_o = '{ptime: point_time_i, pval: point_value_i};
    mem_raddr_o = '0;
    rom_addr_o  = k_q;
    arith_ctrl_o = '0;
    arith_ctrl_o.divisor = t2_q - t1_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_CLEAR: begin
              count_d = '0;
              pos_d   = '0;
            end
            ACT_APPEND: begin
              if (count_q < CntW'(MaxPoints)) begin
                mem_we_o = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            ACT_PROCESS: begin
              left_d  = left_in_i;
              right_d = right_in_i;
              if (count_q == '0) begin
                env_d   = '0;
                state_d = S_GAIN_MUL;
              end else begin
                state_d = S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIRST: begin
        if (pos_q <= mem_rdata_i.ptime) begin
          env_d   = mem_rdata_i.pval;
          state_d = S_GAIN_MUL;
        end else begin
          mem_raddr_o = AddrW'(count_q - 1'b1);
          state_d     = S_LAST;
        end
      end
      S_LAST: begin
        if (pos_q >= mem_rdata_i.ptime) begin
          env_d   = mem_rdata_i.pval;
          state_d = S_GAIN_MUL;
        end else begin
          last_d  = mem_rdata_i.pval;
          state_d = S_SCAN0;
        end
      end
      S_SCAN0: begin
        t1_d        = mem_rdata_i.ptime;
        v1_d        = mem_rdata_i.pval;
        idx_d       = AddrW'(1);
        mem_raddr_o = AddrW'(1);
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (mem_rdata_i.ptime == t1_q) begin
            env_d   = v1_q;
            state_d = S_GAIN_MUL;
          end else begin
            t2_d    = mem_rdata_i.ptime;
            diff_d  = {mem_rdata_i.pval[VALUE_W-1], mem_rdata_i.pval} -
                      {v1_q[VALUE_W-1], v1_q};
            state_d = S_INTERP_MUL;
          end
        end else if (({1'b0, idx_q} + 1'b1) < CntW'(count_q)) begin
          // advance to the next segment
          t1_d        = mem_rdata_i.ptime;
          v1_d        = mem_rdata_i.pval;
          idx_d       = idx_q + 1'b1;
          mem_raddr_o = idx_q + 1'b1;
        end else begin
          env_d   = last_q;
          state_d = S_GAIN_MUL;
        end
      end
      S_INTERP_MUL: begin
        arith_ctrl_o.mul_go = 1'b1;
        arith_ctrl_o.a      = {1'b0, pos_q - t1_q};
        arith_ctrl_o.b      = {{(MUL_B_W-VALUE_W-1){diff_q[VALUE_W]}}, diff_q};
        state_d             = S_DIV_GO;
      end
      S_DIV_GO: begin
        arith_ctrl_o.div_go = 1'b1;
        state_d             = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!arith_stat_i.busy) begin
          env_d   = interp[VALUE_W-1:0];
          state_d = S_GAIN_MUL;
        end
      end
      S_GAIN_MUL: begin
        arith_ctrl_o.mul_go = 1'b1;
        arith_ctrl_o.b      = {{(MUL_B_W-INT_W){1'b0}}, intensity_i};
        if (!mode_i) begin
          arith_ctrl_o.a = {{(MUL_A_W-VALUE_W-1){env_m1[VALUE_W]}}, env_m1};
          state_d        = S_GAIN_FIX;
        end else begin
          arith_ctrl_o.a = {{(MUL_A_W-VALUE_W){env_q[VALUE_W-1]}}, env_q};
          state_d        = S_PAN_CLAMP;
        end
      end
      S_GAIN_FIX: begin
        gl_d    = g_full[MUL_B_W-1:0];
        gr_d    = g_full[MUL_B_W-1:0];
        state_d = S_MUL_L;
      end
      S_PAN_CLAMP: begin
        // scale the offset pan position by the table size
        arith_ctrl_o.mul_go = 1'b1;
        arith_ctrl_o.a      = MUL_A_W'(p_clamp + PanLim);
        arith_ctrl_o.b      = MUL_B_W'(PanTableSize);
        state_d             = S_PAN_IDX;
      end
      S_PAN_IDX: begin
        k_d        = (k_sh > KW'(PanTableSize)) ? RomAW'(PanTableSize) : k_sh[RomAW-1:0];
        rom_addr_o = k_d;
        state_d    = S_ROM_R;
      end
      S_ROM_R: begin
        gr_d       = MUL_B_W'(rom_data_i);
        rom_addr_o = RomAW'(PanTableSize) - k_q;
        state_d    = S_ROM_L;
      end
      S_ROM_L: begin
        gl_d    = MUL_B_W'(rom_data_i);
        state_d = S_MUL_L;
      end
      S_MUL_L: begin
        arith_ctrl_o.mul_go = 1'b1;
        arith_ctrl_o.a      = MUL_A_W'(left_q);
        arith_ctrl_o.b      = gl_q;
        state_d             = S_MUL_R;
      end
      S_MUL_R: begin
        lo_d                = round_sat(arith_stat_i.prod);
        arith_ctrl_o.mul_go = 1'b1;
        arith_ctrl_o.a      = MUL_A_W'(right_q);
        arith_ctrl_o.b      = gr_q;
        state_d             = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          lout_d      = lo_q;
          rout_d      = round_sat(arith_stat_i.prod);
          eout_d      = env_q;
          out_valid_d = 1'b1;
          pos_d       = pos_q + 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    t1_q    <= t1_d;
    t2_q    <= t2_d;
    v1_q    <= v1_d;
    last_q  <= last_d;
    env_q   <= env_d;
    diff_q  <= diff_d;
    left_q  <= left_d;
    right_q <= right_d;
    gl_q    <= gl_d;
    gr_q    <= gr_d;
    k_q     <= k_d;
    lo_q    <= lo_d;
    lout_q  <= lout_d;
    rout_q  <= rout_d;
    eout_q  <= eout_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign left_out_o       = lout_q;
  assign right_out_o      = rout_q;
  assign envelope_level_o = eout_q;

endmodule

// ===== rtl/core/breakpoint_envelope_gain_pan_top.sv =====
// Top level of the breakpoint envelope gain/pan block: config registers and
// the wiring of sequencer, breakpoint table, sine ROM and arithmetic unit.
// Depends on bpegp_pkg, bpegp_point_mem, bpegp_sine_rom, bpegp_arith, bpegp_ctrl.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: action 0 clears
//   the table and the sample position, action 1 appends a breakpoint (dropped
//   when the table is full), action 2 processes one stereo frame. Code 3 is
//   ignored. Clear, append and ignored items leave the sequencer idle.
//   A frame item yields one result on the output channel (out_valid_o/
//   out_ready_i): scaled left/right samples and the envelope level used.
//   Frame steps: an empty table goes straight to the gain or pan step; else
//   the first and then the last breakpoint are checked, and a position that
//   lies between them starts a scan that visits segments in turn. Interpolation
//   adds a product, a divide launch and a 53-step serial divide. The input is
//   ready again in the same cycle that out_valid_o rises. The single memory
//   read port and the shared multiply/divide unit keep these steps serial.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the following frame holds in its last
//   step until the register frees up.
//   Reset clears the table count, the sample position, the output valid,
//   intensity to 1.0 and mode to amplitude. Table contents are not cleared.
//   APB: intensity at 0x0, mode at 0x4, writes take effect at the access phase.
module breakpoint_envelope_gain_pan_top #(
  parameter int MaxPoints    = bpegp_pkg::DEFAULT_MAX_POINTS,
  parameter int SampleBits   = bpegp_pkg::DEFAULT_SAMPLE_BITS,
  parameter int PanTableSize = bpegp_pkg::DEFAULT_PAN_TABLE_SIZE
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [bpegp_pkg::TIME_W-1:0]          point_time_i,
  input  logic signed [bpegp_pkg::VALUE_W-1:0]  point_value_i,
  input  logic signed [SampleBits-1:0]          left_in_i,
  input  logic signed [SampleBits-1:0]          right_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SampleBits-1:0]          left_out_o,
  output logic signed [SampleBits-1:0]          right_out_o,
  output logic signed [bpegp_pkg::VALUE_W-1:0]  envelope_level_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bpegp_pkg::ADDR_W-1:0]          paddr,
  input  logic [bpegp_pkg::DATA_W-1:0]          pwdata,
  output logic [bpegp_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);
  import bpegp_pkg::*;

  localparam int AddrW = $clog2(MaxPoints);
  localparam int RomAW = $clog2(PanTableSize + 1);

  logic [INT_W-1:0]   intensity_q;
  logic               mode_q;
  logic               cfg_wr;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  point_t             mem_wdata, mem_rdata;
  logic [RomAW-1:0]   rom_addr;
  logic [GAIN_W-1:0]  rom_data;
  arith_ctrl_t        arith_ctrl;
  arith_stat_t        arith_stat;

  // Register write at the access phase; pready never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= INTENSITY_RESET;
      mode_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_INTENSITY: intensity_q <= pwdata[INT_W-1:0];
        REG_MODE:      mode_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INTENSITY: prdata = {{(DATA_W-INT_W){1'b0}}, intensity_q};
      REG_MODE:      prdata = {{(DATA_W-1){1'b0}}, mode_q};
      default:       prdata = '0;
    endcase
  end

  bpegp_point_mem #(.MaxPoints(MaxPoints)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpegp_sine_rom #(.PanTableSize(PanTableSize)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  bpegp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (arith_ctrl),
    .stat_o (arith_stat)
  );

  bpegp_ctrl #(
    .MaxPoints    (MaxPoints),
    .SampleBits   (SampleBits),
    .PanTableSize (PanTableSize)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .point_time_i     (point_time_i),
    .point_value_i    (point_value_i),
    .left_in_i        (left_in_i),
    .right_in_i       (right_in_i),
    .intensity_i      (intensity_q),
    .mode_i           (mode_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .envelope_level_o (envelope_level_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .rom_addr_o       (rom_addr),
    .rom_data_i       (rom_data),
    .arith_ctrl_o     (arith_ctrl),
    .arith_stat_i     (arith_stat)
  );

endmodule

// ===== rtl/core/bpegp_checker.sv =====
// Port-level checks for the breakpoint envelope gain/pan top, bound to it.
// Depends on bpegp_pkg and breakpoint_envelope_gain_pan_top.
module bpegp_checker #(
  parameter int SampleBits = bpegp_pkg::DEFAULT_SAMPLE_BITS
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic [1:0]                           action_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [SampleBits-1:0]         left_out_o,
  input logic signed [SampleBits-1:0]         right_out_o,
  input logic signed [bpegp_pkg::VALUE_W-1:0] envelope_level_o
);
  import bpegp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(left_out_o) && $stable(right_out_o) &&
                                    $stable(envelope_level_o))
    else $error("stalled result changed");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after an item");

  a_busy_on_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_PROCESS) |=> !in_ready_o)
    else $error("ready while a frame is in work");

  a_ready_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i != ACT_PROCESS) |=> in_ready_o)
    else $error("not ready after a table item");

endmodule

bind breakpoint_envelope_gain_pan_top bpegp_checker #(.SampleBits(SampleBits)) u_bpegp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .action_i         (action_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .left_out_o       (left_out_o),
  .right_out_o      (right_out_o),
  .envelope_level_o (envelope_level_o)
);
